/* rtl/adc_buffer_level_statistics_core_defines.svh */
// Assertion macros shared by the RTL files.
`ifndef ADC_BUFFER_LEVEL_STATISTICS_CORE_DEFINES_SVH
`define ADC_BUFFER_LEVEL_STATISTICS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ABLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ABLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ABLS_ASSERT(label, clk, rst_n, prop, msg)
`define ABLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/abls_pkg.sv */
package abls_pkg;
  localparam int unsigned MaxSamplesDefault = 4096;
  localparam int unsigned SampleBitsDefault = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegLevelOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHighThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHighCountNeeded = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStatsMode = 2'd3;
  localparam int unsigned MeanW = 24;
  localparam int unsigned SumW = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;       // Fold the accepted sample into the statistics.
    logic div_start;   // Start a division.
    logic div_sel_dev; // Divide the deviation sum instead of the sample sum.
    logic rd_start;    // Start the deviation pass.
    logic dev_step;    // Issue one stored sample read this cycle.
    logic clear;       // Return the buffer statistics to zero.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic dev_idle;    // No stored sample read or its divide is in flight.
    logic pass_done;
    logic empty;
  } status_t;
endpackage

/* rtl/abls_if.sv */
interface abls_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface abls_out_if;
  logic        valid;
  logic        ready;
  logic        detected;
  logic [15:0] level_min;
  logic [15:0] level_max;
  logic [23:0] dc_mean;
  logic [23:0] ac_mean;
  modport source (output valid, detected, level_min, level_max, dc_mean, ac_mean,
                  input ready);
  modport sink (input valid, detected, level_min, level_max, dc_mean, ac_mean,
                output ready);
endinterface

/* rtl/abls_ram.sv */
module abls_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/abls_div.sv */
// Restoring divider, one quotient bit per cycle.
module abls_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;

  // One shift and subtract step.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

/* rtl/abls_datapath.sv */
`include "adc_buffer_level_statistics_core_defines.svh"
// Statistics registers, sample store, deviation pass and shared divider.
module abls_datapath #(
  parameter int unsigned MaxSamples = abls_pkg::MaxSamplesDefault,
  parameter int unsigned SampleBits = abls_pkg::SampleBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  abls_pkg::cmd_t       cmd_i,
  output abls_pkg::status_t    status_o,
  input  logic [15:0]          sample_i,
  input  logic [15:0]          level_offset_i,
  input  logic [15:0]          high_threshold_i,
  input  logic [15:0]          high_count_needed_i,
  output logic                 detected_o,
  output logic [15:0]          min_o,
  output logic [15:0]          max_o,
  output logic [23:0]          dc_mean_o,
  output logic [23:0]          ac_mean_o
);
  localparam int unsigned AddrW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned SumW  = abls_pkg::SumW;
  localparam int unsigned ProdW = SumW + CntW;
  localparam int unsigned NumW  = SumW + 8 + 8;
  localparam int unsigned XnW   = SampleBits + CntW;

  logic [SampleBits-1:0] s;
  logic [CntW-1:0]       count_q, count_d, rd_cnt_q, rd_cnt_d;
  logic [15:0]           min_q, min_d, max_q, max_d, high_q, high_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic                  det_q, det_d, full;
  logic [16:0]           thr;
  logic [SampleBits-1:0] rdata;
  logic [XnW-1:0]        xn_raw;
  logic [ProdW-1:0]      xn_q, diff;
  logic                  rd_v_q, xn_v_q, dev_idle;
  logic [SumW-1:0]       dev_num;
  logic [NumW-1:0]       dev_sum_q, dev_sum_d;
  logic                  ddiv_start, ddiv_busy, ddiv_pend_q, ddiv_busy_q;
  logic [NumW-1:0]       ddiv_quo, div_num;
  logic                  div_busy;
  logic [NumW-1:0]       div_quo;
  logic                  div_res_sel_q;
  logic                  div_done_q;
  logic [23:0]           dc_q, ac_q;

  assign s    = sample_i[SampleBits-1:0];
  assign full = (count_q == CntW'(MaxSamples));
  assign thr  = {1'b0, level_offset_i} + {1'b0, high_threshold_i};

  // Running statistics for the sample phase.
  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    high_d  = high_q;
    det_d   = det_q;
    if (cmd_i.clear) begin
      count_d = '0;
      sum_d   = '0;
      high_d  = '0;
      det_d   = 1'b0;
    end else if (cmd_i.accum && !full) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + SumW'(s);
      if (count_q == '0 || 16'(s) < min_q) min_d = 16'(s);
      if (count_q == '0 || 16'(s) > max_q) max_d = 16'(s);
      if ({1'b0, 16'(s)} > thr) begin
        high_d = high_q + 1'b1;
        if (high_d == high_count_needed_i) det_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      high_q  <= '0;
      det_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      high_q  <= high_d;
      det_q   <= det_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
  end

  abls_ram #(.Width(SampleBits), .Depth(MaxSamples)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accum && !full),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (s),
    .raddr_i (rd_cnt_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Read address for the deviation pass; it returns to zero with the buffer.
  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.rd_start || cmd_i.clear) rd_cnt_d = '0;
    else if (cmd_i.dev_step) rd_cnt_d = rd_cnt_q + 1'b1;
  end

  // The RAM registers the read data after dev_step, and xn_q then registers the product.
  // Then the absolute difference is divided by the count in its own serial divider.
  assign xn_raw = XnW'(rdata) * XnW'(count_q);
  assign diff = (xn_q >= ProdW'(sum_q)) ? xn_q - ProdW'(sum_q) : ProdW'(sum_q) - xn_q;
  assign dev_num = diff[SumW-1:0];
  assign ddiv_start = xn_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q    <= '0;
      rd_v_q      <= 1'b0;
      xn_v_q      <= 1'b0;
      ddiv_pend_q <= 1'b0;
      ddiv_busy_q <= 1'b0;
      dev_sum_q   <= '0;
    end else begin
      rd_cnt_q    <= rd_cnt_d;
      rd_v_q      <= cmd_i.dev_step;
      xn_v_q      <= rd_v_q;
      ddiv_busy_q <= ddiv_busy;
      ddiv_pend_q <= ddiv_start || (ddiv_pend_q && ddiv_busy);
      dev_sum_q   <= dev_sum_d;
    end
  end

  always_comb begin
    dev_sum_d = dev_sum_q;
    if (cmd_i.rd_start) dev_sum_d = '0;
    else if (ddiv_pend_q && ddiv_busy_q && !ddiv_busy) dev_sum_d = dev_sum_q + ddiv_quo;
  end

  always_ff @(posedge clk_i) begin
    xn_q <= ProdW'(xn_raw);
  end

  abls_div #(.NumW(NumW), .DenW(CntW)) u_ddiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ddiv_start),
    .num_i   (NumW'(dev_num)),
    .den_i   (count_q),
    .busy_o  (ddiv_busy),
    .quo_o   (ddiv_quo)
  );

  // Final divides for the two means share one divider.
  assign div_num = cmd_i.div_sel_dev ? {dev_sum_q[NumW-9:0], 8'd0}
                                     : {8'd0, sum_q, 8'd0};

  abls_div #(.NumW(NumW), .DenW(CntW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (count_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_done_q    <= 1'b0;
      div_res_sel_q <= 1'b0;
    end else begin
      if (cmd_i.div_start) div_res_sel_q <= cmd_i.div_sel_dev;
      div_done_q <= cmd_i.div_start || (div_done_q && div_busy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done_q && !div_busy && !cmd_i.div_start) begin
      if (div_res_sel_q) ac_q <= div_quo[23:0];
      else dc_q <= div_quo[23:0];
    end
  end

  assign dev_idle = !cmd_i.dev_step && !rd_v_q && !xn_v_q && !ddiv_pend_q && !ddiv_busy;

  assign status_o.div_busy  = div_busy || cmd_i.div_start || (div_done_q && div_busy);
  assign status_o.dev_idle  = dev_idle;
  assign status_o.pass_done = (rd_cnt_q == count_q) && dev_idle;
  assign status_o.empty     = (count_q == '0);

  assign detected_o = det_q;
  assign min_o      = min_q;
  assign max_o      = max_q;
  assign dc_mean_o  = dc_q;
  assign ac_mean_o  = ac_q;

  `ABLS_ASSERT(a_count_le_max, clk_i, rst_ni, count_q <= CntW'(MaxSamples), "count overflow")
  `ABLS_ASSERT(a_rd_le_count, clk_i, rst_ni, rd_cnt_q <= count_q, "pass ran past the count")
  `ABLS_ASSERT_NEXT(a_clear, clk_i, rst_ni, cmd_i.clear, count_q == '0 && high_q == '0,
                    "clear failed")
endmodule

/* rtl/abls_ctrl.sv */
`include "adc_buffer_level_statistics_core_defines.svh"
// Sequencer: sample intake, deviation pass, two divisions, result hand-off.
module abls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              stats_mode_i,
  input  abls_pkg::status_t status_i,
  output abls_pkg::cmd_t    cmd_o,
  output logic              values_o
);
  typedef enum logic [2:0] {
    StIntake, StDcStart, StDcDiv, StPass, StAcDiv, StWait, StOut
  } state_e;

  state_e state_q;
  logic   values_q;
  logic   in_xfer;
  logic   step_q;

  assign in_ready_o  = (state_q == StIntake);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign values_o    = values_q;

  // Commands follow from the state and the handshakes.
  always_comb begin
    cmd_o = '0;
    cmd_o.accum = in_xfer;
    // The mean divide starts once the last sample is in the sum and the count.
    cmd_o.div_start = (state_q == StDcStart);
    if (state_q == StDcDiv && !status_i.div_busy) cmd_o.rd_start = 1'b1;
    cmd_o.dev_step    = (state_q == StPass) && step_q;
    if (state_q == StPass && status_i.pass_done && !step_q) begin
      cmd_o.div_start   = 1'b1;
      cmd_o.div_sel_dev = 1'b1;
    end
    cmd_o.clear = (state_q == StOut) && out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIntake;
      values_q <= 1'b0;
      step_q   <= 1'b0;
    end else begin
      case (state_q)
        StIntake: begin
          if (in_xfer && in_last_i) begin
            values_q <= stats_mode_i;
            state_q  <= stats_mode_i ? StDcStart : StOut;
          end
        end
        StDcStart: state_q <= StDcDiv;
        StDcDiv: begin
          if (!status_i.div_busy) begin
            if (status_i.empty) begin
              values_q <= 1'b0;
              state_q  <= StOut;
            end else begin
              step_q  <= 1'b1;
              state_q <= StPass;
            end
          end
        end
        StPass: begin
          // One read, then wait for its divide before the next one.
          if (step_q) step_q <= 1'b0;
          else if (status_i.pass_done) state_q <= StAcDiv;
          else if (status_i.dev_idle) step_q <= 1'b1;
        end
        StAcDiv: state_q <= StWait;
        StWait: if (!status_i.div_busy) state_q <= StOut;
        StOut: if (out_ready_i) state_q <= StIntake;
        default: state_q <= StIntake;
      endcase
    end
  end

  `ABLS_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o), "both sides open")
  `ABLS_ASSERT_NEXT(a_last_leaves, clk_i, rst_ni, in_xfer && in_last_i, !in_ready_o,
                    "intake stayed open after the last sample")
  `ABLS_ASSERT_NEXT(a_out_done, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o,
                    "result transfer did not reopen intake")
endmodule

/* rtl/adc_buffer_level_statistics_core.sv */
// ADC buffer level statistics. Samples stream in one per cycle while intake
// is open and are stored, while min, max, sum and the high-sample count
// update; detection fires when the high count equals the needed count (a
// needed count of zero never fires). Intake is closed from the last sample
// until the result transfer. Outside values mode the result is offered in the
// cycle after the last sample. In values mode a serial divider first finds the
// mean; then each stored sample is read back, its absolute deviation scaled by
// the count is divided by the count in a second serial divider, and the next
// sample is read only when that divide is done; a last division gives the mean
// deviation. Buffers longer than MaxSamples drop the extra samples.
module adc_buffer_level_statistics_core #(
  parameter int unsigned MaxSamples = abls_pkg::MaxSamplesDefault,
  parameter int unsigned SampleBits = abls_pkg::SampleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  abls_in_if.sink                      in_ch,
  abls_out_if.source                   out_ch,
  input  logic                         cfg_we_i,
  input  logic [abls_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [abls_pkg::CfgDataW-1:0] cfg_data_i
);
  logic [15:0] level_offset_q, high_threshold_q, high_count_needed_q;
  logic        stats_mode_q;
  abls_pkg::cmd_t    cmd;
  abls_pkg::status_t status;
  logic        values, det;
  logic [15:0] mn, mx;
  logic [23:0] dc, ac;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_offset_q      <= '0;
      high_threshold_q    <= '0;
      high_count_needed_q <= '0;
      stats_mode_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abls_pkg::RegLevelOffset:     level_offset_q      <= cfg_data_i;
        abls_pkg::RegHighThreshold:   high_threshold_q    <= cfg_data_i;
        abls_pkg::RegHighCountNeeded: high_count_needed_q <= cfg_data_i;
        abls_pkg::RegStatsMode:       stats_mode_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  abls_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_last_i    (in_ch.last_sample),
    .in_ready_o   (in_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .stats_mode_i (stats_mode_q),
    .status_i     (status),
    .cmd_o        (cmd),
    .values_o     (values)
  );

  abls_datapath #(.MaxSamples(MaxSamples), .SampleBits(SampleBits)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .sample_i            (in_ch.sample),
    .level_offset_i      (level_offset_q),
    .high_threshold_i    (high_threshold_q),
    .high_count_needed_i (high_count_needed_q),
    .detected_o          (det),
    .min_o               (mn),
    .max_o               (mx),
    .dc_mean_o           (dc),
    .ac_mean_o           (ac)
  );

  // Min, max and mean fields read as zero outside values mode.
  assign out_ch.detected  = det;
  assign out_ch.level_min = values ? mn : '0;
  assign out_ch.level_max = values ? mx : '0;
  assign out_ch.dc_mean   = values ? dc : '0;
  assign out_ch.ac_mean   = values ? ac : '0;
endmodule
